// File: rtl/core/crcpc_pkg.sv
// crcpc_pkg: types, constants and byte-wide helper functions of the record checker
// used by the interfaces and all modules under rtl/core; no dependencies
package crcpc_pkg;

    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOR_OUT    = 32'hFFFF_FFFF;
    localparam logic [7:0]  DELIM_RESET    = 8'h09;
    localparam logic [3:0]  MAX_DIGITS     = 4'd8;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_DELIM   = 2'd1,
        ST_BAD_PREFIX = 2'd2,
        ST_MISMATCH   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       is_last;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] received_crc;
        logic [31:0] computed_crc;
    } result_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        logic is_bad;
        logic [3:0] value;
    } hex_digit_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic hex_digit_t hex_value(input logic [7:0] b);
        hex_digit_t d;
        d.is_bad = 1'b0;
        d.value  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            d.value = b[3:0];
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            d.value = b[3:0] + 4'd9;
        end
        else
        begin
            d.is_bad = 1'b1;
        end
        return d;
    endfunction

endpackage

// File: rtl/core/crcpc_if.sv
// crcpc_if: valid/ready channel interfaces for bytes, results and the delimiter register
// depends on crcpc_pkg
interface crcpc_byte_if import crcpc_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] record_byte;
    logic       is_last;

    modport source (output valid, output record_byte, output is_last, input ready);
    modport sink   (input valid, input record_byte, input is_last, output ready);
endinterface

interface crcpc_result_if import crcpc_pkg::*;;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] received_crc;
    logic [31:0] computed_crc;

    modport source (output valid, output status, output received_crc, output computed_crc,
                    input ready);
    modport sink   (input valid, input status, input received_crc, input computed_crc,
                    output ready);
endinterface

interface crcpc_cfg_if import crcpc_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] delimiter_byte;

    modport source (output valid, output delimiter_byte, input ready);
    modport sink   (input valid, input delimiter_byte, output ready);
endinterface

// File: rtl/core/crcpc_in_stage.sv
// crcpc_in_stage: input register holding one byte transaction until the record logic takes it
// depends on crcpc_pkg and crcpc_if
module crcpc_in_stage import crcpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    crcpc_byte_if.sink    bytes,
    input  logic          take,
    output stage_t        stage
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign bytes.ready = !valid_reg || take;
    assign accept      = bytes.valid && bytes.ready;
    assign valid_next  = accept || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.record_byte <= bytes.record_byte;
            item_reg.is_last     <= bytes.is_last;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: rtl/core/crcpc_record.sv
// crcpc_record: per-record state, hex prefix parse, byte-wide crc-32 and result decision
// depends on crcpc_pkg
module crcpc_record import crcpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_t     stage,
    input  logic [7:0] delimiter,
    input  logic       slot_free,
    output logic       take,
    output logic       res_load,
    output result_t    res
);

    logic        in_content_reg;
    logic        in_content_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [3:0]  digit_count_reg;
    logic [3:0]  digit_count_next;
    logic        prefix_bad_reg;
    logic        prefix_bad_next;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_final;
    hex_digit_t  digit;
    logic [7:0]  b;

    assign b        = stage.item.record_byte;
    assign digit    = hex_value(b);
    assign take     = stage.valid && (!stage.item.is_last || slot_free);
    assign res_load = take && stage.item.is_last;

    always_comb
    begin
        in_content_next  = in_content_reg;
        acc_next         = acc_reg;
        digit_count_next = digit_count_reg;
        prefix_bad_next  = prefix_bad_reg;
        crc_next         = crc_reg;
        if (in_content_reg)
        begin
            crc_next = crc_byte(crc_reg, b);
        end
        else if (b == delimiter)
        begin
            in_content_next = 1'b1;
            if (digit_count_reg == 4'd0)
            begin
                prefix_bad_next = 1'b1;
            end
        end
        else if (digit.is_bad || digit_count_reg >= MAX_DIGITS)
        begin
            prefix_bad_next = 1'b1;
        end
        else
        begin
            acc_next         = {acc_reg[27:0], digit.value};
            digit_count_next = digit_count_reg + 4'd1;
        end
    end

    assign crc_final = crc_next ^ CRC_XOR_OUT;

    always_comb
    begin
        res.status       = ST_OK;
        res.received_crc = 32'd0;
        res.computed_crc = crc_final;
        priority if (!in_content_next)
        begin
            res.status       = ST_NO_DELIM;
            res.computed_crc = 32'd0;
        end
        else if (prefix_bad_next)
        begin
            res.status = ST_BAD_PREFIX;
        end
        else
        begin
            res.received_crc = acc_next;
            res.status       = (acc_next == crc_final) ? ST_OK : ST_MISMATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_content_reg  <= 1'b0;
            acc_reg         <= 32'd0;
            digit_count_reg <= 4'd0;
            prefix_bad_reg  <= 1'b0;
            crc_reg         <= CRC_INIT;
        end
        else if (res_load)
        begin
            in_content_reg  <= 1'b0;
            acc_reg         <= 32'd0;
            digit_count_reg <= 4'd0;
            prefix_bad_reg  <= 1'b0;
            crc_reg         <= CRC_INIT;
        end
        else if (take)
        begin
            in_content_reg  <= in_content_next;
            acc_reg         <= acc_next;
            digit_count_reg <= digit_count_next;
            prefix_bad_reg  <= prefix_bad_next;
            crc_reg         <= crc_next;
        end
    end

    // record state is back to its initial values after the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (!in_content_reg && !prefix_bad_reg && digit_count_reg == 4'd0
                      && acc_reg == 32'd0 && crc_reg == CRC_INIT))
        else $error("record state not cleared after final byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= MAX_DIGITS)
        else $error("digit count beyond limit");

    // no prefix or crc digits move once content has started
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !res_load && in_content_reg) |=>
            (in_content_reg && $stable(acc_reg) && $stable(digit_count_reg)))
        else $error("prefix state changed during content");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.status == ST_NO_DELIM) |->
            (res.received_crc == 32'd0 && res.computed_crc == 32'd0))
        else $error("missing delimiter result carries checksum values");

endmodule

// File: rtl/core/crcpc_out_stage.sv
// crcpc_out_stage: result register driving the result channel
// depends on crcpc_pkg and crcpc_if
module crcpc_out_stage import crcpc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  result_t        res,
    output logic           slot_free,
    crcpc_result_if.source result
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign slot_free  = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid        = valid_reg;
    assign result.status       = res_reg.status;
    assign result.received_crc = res_reg.received_crc;
    assign result.computed_crc = res_reg.computed_crc;

endmodule

// File: rtl/core/crc32_prefixed_record_checker_unit.sv
// Record checker: one byte transaction per cycle is accepted, also while a result waits.
// Each byte sits in the input register until the record logic takes it, then the hex
// prefix step or the byte-wide crc-32 update (reflected, init and final xor all ones) runs
// and the final byte of a record loads the result register, so a result is registered
// after the input register. The sustained rate is one byte per cycle, set by the crc update
// and result compare between the input and result registers; only a stalled result channel
// holding a final byte back slows it. The delimiter register resets to tab.
// depends on crcpc_pkg, crcpc_if, crcpc_in_stage, crcpc_record, crcpc_out_stage
module crc32_prefixed_record_checker_unit import crcpc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    crcpc_byte_if.sink     bytes,
    crcpc_result_if.source result,
    crcpc_cfg_if.sink      cfg
);

    logic [7:0] delim_reg;
    stage_t     stage;
    logic       take;
    logic       res_load;
    logic       slot_free;
    result_t    res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            delim_reg <= cfg.delimiter_byte;
        end
    end

    crcpc_in_stage u_in_stage
    (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .take  (take),
        .stage (stage)
    );

    crcpc_record u_record
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .delimiter (delim_reg),
        .slot_free (slot_free),
        .take      (take),
        .res_load  (res_load),
        .res       (res)
    );

    crcpc_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .slot_free (slot_free),
        .result    (result)
    );

endmodule

// File: test/crc32_prefixed_record_checker_unit_tb.sv
// crc32_prefixed_record_checker_unit_tb: self-checking testbench of the hex-prefixed crc-32 record
// checker, predicts each result from the accepted bytes and compares it on the result channel
// depends on crcpc_pkg, crcpc_if and crc32_prefixed_record_checker_unit
module crc32_prefixed_record_checker_unit_tb;
    import crcpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    crcpc_byte_if   byte_ch ();
    crcpc_result_if res_ch ();
    crcpc_cfg_if    cfg_ch ();

    crc32_prefixed_record_checker_unit i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    logic [7:0]  delim_now     = DELIM_RESET;
    logic        in_body       = 1'b0;
    logic [31:0] hex_acc       = 32'd0;
    logic [3:0]  hex_digits    = 4'd0;
    logic        prefix_broken = 1'b0;
    logic [31:0] crc_run       = 32'hFFFF_FFFF;

    result_t     pending_results[$];
    logic [7:0]  rec_bytes[$];

    bit idle_on     = 1'b1;
    int hold_cycles = 0;
    int errors      = 0;
    int bytes_sent  = 0;
    int cycles      = 0;

    always #10 clk = ~clk;

    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0] ^ b[k])
            begin
                c = (c >> 1) ^ 32'hEDB8_8320;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= "0" && b <= "9")
        begin
            return {1'b0, 4'(b - 8'h30)};
        end
        if (b >= "a" && b <= "f")
        begin
            return {1'b0, 4'(b - 8'h57)};
        end
        if (b >= "A" && b <= "F")
        begin
            return {1'b0, 4'(b - 8'h37)};
        end
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
        begin
            return 8'h30 + 8'(nib);
        end
        return (upper ? 8'h37 : 8'h57) + 8'(nib);
    endfunction

    function automatic void clear_record_state();
        in_body       = 1'b0;
        hex_acc       = 32'd0;
        hex_digits    = 4'd0;
        prefix_broken = 1'b0;
        crc_run       = 32'hFFFF_FFFF;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic last);
        logic [4:0] nib;
        result_t    r;
        nib = nibble_of(b);
        if (in_body)
        begin
            crc_run = crc32_update(crc_run, b);
        end
        else if (b == delim_now)
        begin
            if (hex_digits == 4'd0)
            begin
                prefix_broken = 1'b1;
            end
            in_body = 1'b1;
        end
        else if (nib[4] || hex_digits >= MAX_DIGITS)
        begin
            prefix_broken = 1'b1;
        end
        else
        begin
            hex_acc    = {hex_acc[27:0], nib[3:0]};
            hex_digits = hex_digits + 4'd1;
        end
        if (last)
        begin
            r.computed_crc = ~crc_run;
            r.received_crc = 32'd0;
            if (!in_body)
            begin
                r.status       = ST_NO_DELIM;
                r.computed_crc = 32'd0;
            end
            else if (prefix_broken)
            begin
                r.status = ST_BAD_PREFIX;
            end
            else
            begin
                r.received_crc = hex_acc;
                r.status       = (hex_acc == r.computed_crc) ? ST_OK : ST_MISMATCH;
            end
            pending_results.push_back(r);
            clear_record_state();
        end
    endfunction

    function automatic void build_checked_record(input int body_len, input bit corrupt);
        logic [7:0]  body[$];
        logic [31:0] crc;
        logic [31:0] val;
        int          min_dig;
        int          ndig;
        crc = 32'hFFFF_FFFF;
        for (int k = 0; k < body_len; k++)
        begin
            body.push_back(8'($urandom));
            crc = crc32_update(crc, body[k]);
        end
        val = ~crc;
        if (corrupt)
        begin
            val = val ^ (32'd1 << $urandom_range(31));
        end
        min_dig = 1;
        for (int k = 1; k < 8; k++)
        begin
            if ((val >> (4 * k)) != 0)
            begin
                min_dig = k + 1;
            end
        end
        ndig = $urandom_range(8, min_dig);
        rec_bytes.delete();
        for (int k = ndig - 1; k >= 0; k--)
        begin
            rec_bytes.push_back(hex_char(4'(val >> (4 * k)), 1'($urandom_range(1))));
        end
        rec_bytes.push_back(delim_now);
        foreach (body[k])
        begin
            rec_bytes.push_back(body[k]);
        end
    endfunction

    function automatic void build_noise_record();
        int n;
        case ($urandom_range(2))
            0:
            begin
                rec_bytes.delete();
                n = $urandom_range(10, 1);
                repeat (n) rec_bytes.push_back(8'($urandom));
            end
            1:
            begin
                rec_bytes.delete();
                n = $urandom_range(12);
                repeat (n) rec_bytes.push_back(hex_char(4'($urandom), 1'($urandom_range(1))));
                rec_bytes.push_back(delim_now);
                n = $urandom_range(8);
                repeat (n) rec_bytes.push_back(8'($urandom));
            end
            default:
            begin
                build_checked_record($urandom_range(8), 1'b0);
                rec_bytes.insert($urandom_range(2), 8'h47 + 8'($urandom_range(19)));
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 9)
        begin
            byte_ch.valid       = 1'b0;
            byte_ch.record_byte = 8'($urandom);
            byte_ch.is_last     = 1'($urandom);
            @(negedge clk);
        end
        byte_ch.valid       = 1'b1;
        byte_ch.record_byte = b;
        byte_ch.is_last     = last;
        do @(posedge clk); while (!byte_ch.ready);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_record();
        foreach (rec_bytes[k])
        begin
            send_byte(rec_bytes[k], k == rec_bytes.size() - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_delimiter(input logic [7:0] value);
        wait_drained();
        @(negedge clk);
        cfg_ch.valid          = 1'b1;
        cfg_ch.delimiter_byte = value;
        do @(posedge clk); while (!cfg_ch.ready);
        delim_now = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic run_random_records(input int byte_budget);
        int stop_at;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(99) < 70)
            begin
                build_checked_record(($urandom_range(9) == 0) ? $urandom_range(40)
                                                              : $urandom_range(12),
                                     $urandom_range(99) < 15);
            end
            else
            begin
                build_noise_record();
            end
            send_record();
        end
        wait_drained();
    endtask

    task automatic test_directed_records();
        rec_bytes = '{"0", DELIM_RESET};
        send_record();
        rec_bytes = '{DELIM_RESET};
        send_record();
        rec_bytes = '{8'hFF};
        send_record();
        rec_bytes = '{"1", DELIM_RESET};
        send_record();
        rec_bytes = '{"G", DELIM_RESET, 8'h00};
        send_record();
        // nine digits, then a second tab that belongs to the content
        rec_bytes = '{"1", "2", "3", "4", "5", "6", "7", "8", "9", DELIM_RESET, DELIM_RESET};
        send_record();
        // crc-32 of a single zero byte
        rec_bytes = '{"D", "2", "0", "2", "e", "f", "8", "d", DELIM_RESET, 8'h00};
        send_record();
        wait_drained();
    endtask

    task automatic test_delimiter_extremes();
        write_delimiter(8'h00);
        run_random_records(250);
        write_delimiter(8'hFF);
        run_random_records(250);
    endtask

    task automatic test_other_delimiters();
        write_delimiter("a");
        run_random_records(200);
        write_delimiter("5");
        run_random_records(150);
        repeat (3)
        begin
            write_delimiter(8'($urandom));
            run_random_records(150);
        end
        write_delimiter(DELIM_RESET);
        run_random_records(150);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        run_random_records(400);
        idle_on = 1'b1;
    endtask

    task automatic test_result_hold();
        int stop_at;
        hold_cycles = 300;
        stop_at = bytes_sent + 250;
        while (bytes_sent < stop_at)
        begin
            build_checked_record($urandom_range(3), $urandom_range(99) < 15);
            send_record();
        end
        wait_drained();
    endtask

    initial
    begin
        byte_ch.valid         = 1'b0;
        byte_ch.record_byte   = 8'h00;
        byte_ch.is_last       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.delimiter_byte = 8'h00;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_records();
        test_delimiter_extremes();
        test_other_delimiters();
        test_back_to_back();
        test_result_hold();

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
        begin
            $display("crc32_prefixed_record_checker_unit_tb OK");
        end
        else
        begin
            $display("crc32_prefixed_record_checker_unit_tb NOT OK");
        end
        $finish;
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_ch.ready = 1'b0;
                hold_cycles--;
            end
            else
            begin
                res_ch.ready = !(idle_on && $urandom_range(99) < 9);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction status %0d recv %h comp %h",
                         $time, res_ch.status, res_ch.received_crc, res_ch.computed_crc);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if ({res_ch.status, res_ch.received_crc, res_ch.computed_crc} !== want)
                begin
                    $display("%0t: expected status %0d recv %h comp %h, actual %0d %h %h",
                             $time, want.status, want.received_crc, want.computed_crc,
                             res_ch.status, res_ch.received_crc, res_ch.computed_crc);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("crc32_prefixed_record_checker_unit_tb NOT OK");
            $finish;
        end
    end

endmodule

// File: filelist.f
rtl/core/crcpc_pkg.sv
rtl/core/crcpc_if.sv
rtl/core/crcpc_in_stage.sv
rtl/core/crcpc_record.sv
rtl/core/crcpc_out_stage.sv
rtl/core/crc32_prefixed_record_checker_unit.sv
test/crc32_prefixed_record_checker_unit_tb.sv
